>>> rtl/cds_pkg.sv
// shared types, constants and month-length function for the calendar date stepper
package cds_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned KIND_W  = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MIN    = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  YEAR_RST    = YEAR_W'(2000);
  localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR   = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN   = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP   = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV   = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAYS_28     = DAY_W'(28);
  localparam logic [DAY_W-1:0]   DAYS_29     = DAY_W'(29);
  localparam logic [DAY_W-1:0]   DAYS_30     = DAY_W'(30);
  localparam logic [DAY_W-1:0]   DAYS_31     = DAY_W'(31);

  // reciprocal of 100 scaled by 2^19, exact quotient for years up to 9999
  localparam int unsigned RECIP100_W     = 13;
  localparam logic [RECIP100_W-1:0] RECIP100 = RECIP100_W'(5243);
  localparam int unsigned RECIP100_SHIFT = 19;
  localparam int unsigned CENT_W         = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PREV_MONTH = 3'd0,
    KIND_NEXT_MONTH = 3'd1,
    KIND_PREV_DAY   = 3'd2,
    KIND_NEXT_DAY   = 3'd3,
    KIND_LOAD       = 3'd4
  } kind_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // number of days in a month
  function automatic logic [DAY_W-1:0] last_day(input logic [MONTH_W-1:0] month,
                                                input logic leap);
    logic [DAY_W-1:0] days;
    days = DAYS_31;
    if (month == MONTH_FEB) begin
      days = leap ? DAYS_29 : DAYS_28;
    end else if (month == MONTH_APR || month == MONTH_JUN ||
                 month == MONTH_SEP || month == MONTH_NOV) begin
      days = DAYS_30;
    end
    return days;
  endfunction

endpackage

>>> rtl/cds_leap.sv
// leap year test by reciprocal multiply for the century check
module cds_leap (
  input  logic [cds_pkg::YEAR_W-1:0] year,
  output logic                       leap
);
  import cds_pkg::*;

  localparam int unsigned PROD_W = YEAR_W + RECIP100_W;

  logic [PROD_W-1:0] prod;
  logic [CENT_W-1:0] cent;
  logic [YEAR_W-1:0] cent_x100;
  logic              div4;
  logic              div100;
  logic              div400;

  // year / 100 by multiply and shift
  assign prod = PROD_W'(year) * PROD_W'(RECIP100);
  assign cent = prod[RECIP100_SHIFT +: CENT_W];

  // cent * 100 as shifted adds
  assign cent_x100 = (YEAR_W'(cent) << 6) + (YEAR_W'(cent) << 5) + (YEAR_W'(cent) << 2);

  // divisibility flags
  assign div4   = (year[1:0] == 2'b00);
  assign div100 = (cent_x100 == year);
  assign div400 = div100 && (cent[1:0] == 2'b00);
  assign leap   = div4 && (!div100 || div400);

endmodule

>>> rtl/cds_step.sv
// next-date logic for one request, plus leap flag of the resulting year
module cds_step (
  input  logic [cds_pkg::KIND_W-1:0]  kind,
  input  logic [cds_pkg::YEAR_W-1:0]  load_year,
  input  logic [cds_pkg::MONTH_W-1:0] load_month,
  input  logic [cds_pkg::DAY_W-1:0]   load_day,
  input  cds_pkg::date_t              cur,
  input  logic                        cur_leap,
  output cds_pkg::date_t              nxt,
  output logic                        nxt_leap
);
  import cds_pkg::*;

  date_t             back;
  date_t             fwd;
  logic [MONTH_W-1:0] earlier_month;
  logic [DAY_W-1:0]  cur_last;
  logic [DAY_W-1:0]  prev_last;

  // month step back with year borrow, day kept
  always_comb begin
    back = cur;
    if (cur.month <= MONTH_JAN) begin
      back.month = MONTH_DEC;
      if (cur.year > YEAR_MIN) begin
        back.year = cur.year - YEAR_W'(1);
      end
    end else begin
      back.month = cur.month - MONTH_W'(1);
    end
  end

  // month step forward with year carry, day kept
  always_comb begin
    fwd = cur;
    if (cur.month >= MONTH_DEC) begin
      fwd.month = MONTH_JAN;
      if (cur.year < YEAR_MAX) begin
        fwd.year = cur.year + YEAR_W'(1);
      end
    end else begin
      fwd.month = cur.month + MONTH_W'(1);
    end
  end

  // month lengths for current and previous month
  assign earlier_month = (cur.month <= MONTH_JAN) ? MONTH_DEC : cur.month - MONTH_W'(1);
  assign cur_last   = last_day(cur.month, cur_leap);
  assign prev_last  = last_day(earlier_month, cur_leap);

  // command select
  always_comb begin
    nxt = cur;
    unique case (kind)
      KIND_PREV_MONTH: nxt = back;
      KIND_NEXT_MONTH: nxt = fwd;
      KIND_PREV_DAY: begin
        if (cur.day <= DAY_FIRST) begin
          nxt     = back;
          nxt.day = prev_last;
        end else begin
          nxt.day = cur.day - DAY_W'(1);
        end
      end
      KIND_NEXT_DAY: begin
        if (cur.day >= cur_last) begin
          nxt     = fwd;
          nxt.day = DAY_FIRST;
        end else begin
          nxt.day = cur.day + DAY_W'(1);
        end
      end
      KIND_LOAD: begin
        nxt.year  = (load_year < YEAR_MIN) ? YEAR_MIN :
                    ((load_year > YEAR_MAX) ? YEAR_MAX : load_year);
        nxt.month = (load_month < MONTH_JAN) ? MONTH_JAN :
                    ((load_month > MONTH_DEC) ? MONTH_DEC : load_month);
        nxt.day   = (load_day < DAY_FIRST) ? DAY_FIRST : load_day;
      end
      default: nxt = cur;
    endcase
  end

  // leap flag travels with the year register
  cds_leap u_leap (
    .year (nxt.year),
    .leap (nxt_leap)
  );

endmodule

>>> rtl/calendar_date_stepper.sv
// top level of the calendar date stepper: request register, date state, result register
//
// Holds a current Gregorian date and applies one command per request: load a
// date, step one month back or forward, or step one day back or forward.
// Input channel: in_valid/in_ready with in_kind and the in_load_* fields.
// Result channel: out_valid/out_ready with the date after the command.
// Each request gives exactly one result.
// Path: an accepted request goes through the request register, then the
// result register, before it is shown on the result channel.
// Throughput: one request per cycle unless the result is held; the date
// update is a single pass of logic from the request register and the date
// state into the result register, the new year's leap flag computed on the way in.
// Stalls: a held result blocks its own register and the date state; the
// request register still takes one more request, and in_ready drops when both are full.
// Reset: synchronous, active low; the date returns to January 1, 2000 and
// both registers are emptied.
module calendar_date_stepper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cds_pkg::KIND_W-1:0]  in_kind,
  input  logic [cds_pkg::YEAR_W-1:0]  in_load_year,
  input  logic [cds_pkg::MONTH_W-1:0] in_load_month,
  input  logic [cds_pkg::DAY_W-1:0]   in_load_day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cds_pkg::YEAR_W-1:0]  out_cur_year,
  output logic [cds_pkg::MONTH_W-1:0] out_cur_month,
  output logic [cds_pkg::DAY_W-1:0]   out_cur_day
);
  import cds_pkg::*;

  logic               req_vld_r;
  logic [KIND_W-1:0]  req_kind_r;
  logic [YEAR_W-1:0]  req_year_r;
  logic [MONTH_W-1:0] req_month_r;
  logic [DAY_W-1:0]   req_day_r;
  date_t              date_r;
  logic               leap_r;
  logic               out_vld_r;
  date_t              out_date_r;
  date_t              date_nxt;
  logic               leap_nxt;
  logic               advance;

  // handshake
  assign advance  = req_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !req_vld_r || advance;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      req_kind_r  <= in_kind;
      req_year_r  <= in_load_year;
      req_month_r <= in_load_month;
      req_day_r   <= in_load_day;
    end
  end

  // date update
  cds_step u_step (
    .kind       (req_kind_r),
    .load_year  (req_year_r),
    .load_month (req_month_r),
    .load_day   (req_day_r),
    .cur        (date_r),
    .cur_leap   (leap_r),
    .nxt        (date_nxt),
    .nxt_leap   (leap_nxt)
  );

  // date state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_r.year  <= YEAR_RST;
      date_r.month <= MONTH_JAN;
      date_r.day   <= DAY_FIRST;
      leap_r       <= 1'b1;
      out_vld_r    <= 1'b0;
    end else begin
      if (advance) begin
        date_r <= date_nxt;
        leap_r <= leap_nxt;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (advance) begin
      out_date_r <= date_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_cur_year  = out_date_r.year;
  assign out_cur_month = out_date_r.month;
  assign out_cur_day   = out_date_r.day;

endmodule

>>> tb/cds_date_checker.sv
// scoreboard for the calendar date stepper: watches both channels, predicts and compares dates
module cds_date_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [cds_pkg::KIND_W-1:0]  in_kind,
  input  logic [cds_pkg::YEAR_W-1:0]  in_load_year,
  input  logic [cds_pkg::MONTH_W-1:0] in_load_month,
  input  logic [cds_pkg::DAY_W-1:0]   in_load_day,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cds_pkg::YEAR_W-1:0]  out_cur_year,
  input  logic [cds_pkg::MONTH_W-1:0] out_cur_month,
  input  logic [cds_pkg::DAY_W-1:0]   out_cur_day,
  output int unsigned                 mismatches,
  output int unsigned                 pending,
  output int unsigned                 checked
);
  import cds_pkg::*;

  localparam int unsigned MAX_PRINTED = 30;

  date_t tracked_date;
  date_t date_queue[$];
  date_t oldest;

  initial begin
    mismatches   = 0;
    pending      = 0;
    checked      = 0;
    tracked_date = '{year: YEAR_RST, month: MONTH_JAN, day: DAY_FIRST};
  end

  // one line per wrong field, printing capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // gregorian leap rule
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    int unsigned v;
    v = y;
    return (v % 4 == 0) && ((v % 100 != 0) || (v % 400 == 0));
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [YEAR_W-1:0] y,
                                                    input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    len = DAYS_31;
    if (m == MONTH_FEB) begin
      len = leap_year(y) ? DAYS_29 : DAYS_28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAYS_30;
    end
    return len;
  endfunction

  // month back with year borrow, year held at its floor
  function automatic date_t month_earlier(input date_t d);
    date_t r;
    r = d;
    if (d.month <= MONTH_JAN) begin
      r.month = MONTH_DEC;
      if (d.year > YEAR_MIN) r.year = d.year - 1'b1;
    end else begin
      r.month = d.month - 1'b1;
    end
    return r;
  endfunction

  // month forward with year carry, year held at its ceiling
  function automatic date_t month_later(input date_t d);
    date_t r;
    r = d;
    if (d.month >= MONTH_DEC) begin
      r.month = MONTH_JAN;
      if (d.year < YEAR_MAX) r.year = d.year + 1'b1;
    end else begin
      r.month = d.month + 1'b1;
    end
    return r;
  endfunction

  // date after one request
  function automatic date_t step_date(input date_t d, input logic [KIND_W-1:0] kind,
                                      input logic [YEAR_W-1:0] ly,
                                      input logic [MONTH_W-1:0] lm,
                                      input logic [DAY_W-1:0] ld);
    date_t r;
    logic [MONTH_W-1:0] prior_month;
    r = d;
    case (kind)
      KIND_PREV_MONTH: r = month_earlier(d);
      KIND_NEXT_MONTH: r = month_later(d);
      KIND_PREV_DAY: begin
        if (d.day <= DAY_FIRST) begin
          prior_month = (d.month <= MONTH_JAN) ? MONTH_DEC : d.month - 1'b1;
          r.day = month_length(d.year, prior_month);
          r = month_earlier(r);
        end else begin
          r.day = d.day - 1'b1;
        end
      end
      KIND_NEXT_DAY: begin
        if (d.day >= month_length(d.year, d.month)) begin
          r.day = DAY_FIRST;
          r = month_later(r);
        end else begin
          r.day = d.day + 1'b1;
        end
      end
      KIND_LOAD: begin
        r.year  = (ly < YEAR_MIN) ? YEAR_MIN : ((ly > YEAR_MAX) ? YEAR_MAX : ly);
        r.month = (lm < MONTH_JAN) ? MONTH_JAN : ((lm > MONTH_DEC) ? MONTH_DEC : lm);
        r.day   = (ld < DAY_FIRST) ? DAY_FIRST : ld;
      end
      default: r = d;
    endcase
    return r;
  endfunction

  // compare results first, then predict the newly accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      tracked_date = '{year: YEAR_RST, month: MONTH_JAN, day: DAY_FIRST};
      date_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (date_queue.size() == 0) begin
          report_mismatch("result with no request waiting", out_cur_year, 0);
        end else begin
          oldest = date_queue.pop_front();
          checked++;
          if (out_cur_year !== oldest.year) report_mismatch("year", out_cur_year, oldest.year);
          if (out_cur_month !== oldest.month) begin
            report_mismatch("month", out_cur_month, oldest.month);
          end
          if (out_cur_day !== oldest.day) report_mismatch("day", out_cur_day, oldest.day);
        end
      end
      if (in_valid && in_ready) begin
        tracked_date = step_date(tracked_date, in_kind, in_load_year, in_load_month,
                                 in_load_day);
        date_queue.push_back(tracked_date);
      end
    end
    pending = date_queue.size();
  end

endmodule

>>> tb/tb_top.sv
// testbench top for the calendar date stepper: stimulus, flow control and verdict
module tb_top;
  import cds_pkg::*;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned PHASE_ITEMS   = 338;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned LIMIT_CYCLES  = 200000;

  // kinds the block leaves without effect
  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind;
  logic [YEAR_W-1:0]  in_load_year;
  logic [MONTH_W-1:0] in_load_month;
  logic [DAY_W-1:0]   in_load_day;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [YEAR_W-1:0]  out_cur_year;
  logic [MONTH_W-1:0] out_cur_month;
  logic [DAY_W-1:0]   out_cur_day;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_loads        = 0;
  int unsigned n_day_steps    = 0;
  int unsigned n_month_steps  = 0;
  int unsigned n_spare        = 0;

  calendar_date_stepper i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_load_year (in_load_year),
    .in_load_month(in_load_month),
    .in_load_day  (in_load_day),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cur_year (out_cur_year),
    .out_cur_month(out_cur_month),
    .out_cur_day  (out_cur_day)
  );

  cds_date_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_load_year (in_load_year),
    .in_load_month(in_load_month),
    .in_load_day  (in_load_day),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cur_year (out_cur_year),
    .out_cur_month(out_cur_month),
    .out_cur_day  (out_cur_day),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // result side back-pressure, redrawn every cycle
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hard stop in case the handshakes hang
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  // present one request at a falling edge and hold it until accepted
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [YEAR_W-1:0] ly,
                          input logic [MONTH_W-1:0] lm, input logic [DAY_W-1:0] ld);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_load_year  <= ly;
    in_load_month <= lm;
    in_load_day   <= ld;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
    case (kind)
      KIND_LOAD:                       n_loads++;
      KIND_PREV_DAY, KIND_NEXT_DAY:    n_day_steps++;
      KIND_PREV_MONTH, KIND_NEXT_MONTH: n_month_steps++;
      default:                         n_spare++;
    endcase
  endtask

  // mostly steps that walk across month and year edges, some loads near the edges
  task automatic send_random_cmd();
    int unsigned pick;
    int unsigned ysel;
    logic [KIND_W-1:0]  kind;
    logic [YEAR_W-1:0]  ly;
    logic [MONTH_W-1:0] lm;
    logic [DAY_W-1:0]   ld;
    pick = $urandom_range(99);
    ly   = YEAR_W'($urandom);
    lm   = MONTH_W'($urandom);
    ld   = DAY_W'($urandom);
    if (pick < 12) begin
      kind = KIND_LOAD;
      ysel = $urandom_range(5);
      case (ysel)
        0: ly = YEAR_W'($urandom_range(4, 1));
        1: ly = YEAR_W'($urandom_range(9999, 9996));
        2: ly = YEAR_W'($urandom_range(99, 1) * 100 + $urandom_range(4) * 4);
        3: ly = YEAR_W'($urandom_range(24, 1) * 400);
        4: ly = YEAR_W'($urandom_range(9999, 1));
        default: ly = YEAR_W'($urandom);
      endcase
      if ($urandom_range(9) != 0) lm = MONTH_W'($urandom_range(12, 1));
      case ($urandom_range(3))
        0: ld = DAY_W'($urandom_range(3, 1));
        1, 2: ld = DAY_W'($urandom_range(31, 26));
        default: ld = DAY_W'($urandom);
      endcase
    end else if (pick < 16) begin
      kind = KIND_W'($urandom_range(KIND_SPARE_7, KIND_SPARE_5));
    end else if (pick < 40) begin
      kind = ($urandom_range(1) != 0) ? KIND_NEXT_MONTH : KIND_PREV_MONTH;
    end else begin
      kind = ($urandom_range(1) != 0) ? KIND_NEXT_DAY : KIND_PREV_DAY;
    end
    send_cmd(kind, ly, lm, ld);
  endtask

  // reset, directed edge cases, then random phases of flow control
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_LOAD;
    in_load_year  = '0;
    in_load_month = '0;
    in_load_day   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset date, unused kinds and wraps around the new year
    send_cmd(KIND_SPARE_5, '0, '0, '0);
    send_cmd(KIND_PREV_DAY, '0, '0, '0);
    send_cmd(KIND_NEXT_DAY, '0, '0, '0);
    send_cmd(KIND_PREV_MONTH, '0, '0, '0);
    send_cmd(KIND_NEXT_MONTH, '0, '0, '0);
    // loads below range clamp up, year floor holds
    send_cmd(KIND_LOAD, '0, '0, '0);
    send_cmd(KIND_PREV_DAY, '0, '0, '0);
    send_cmd(KIND_SPARE_6, '1, '1, '1);
    // loads above range clamp down, year ceiling holds
    send_cmd(KIND_LOAD, '1, '1, '1);
    send_cmd(KIND_NEXT_DAY, '0, '0, '0);
    send_cmd(KIND_PREV_MONTH, '0, '0, '0);
    send_cmd(KIND_LOAD, YEAR_MAX, MONTH_DEC, 5'd5);
    send_cmd(KIND_NEXT_MONTH, '0, '0, '0);
    // leap rules around february
    send_cmd(KIND_LOAD, 14'd2000, MONTH_FEB, DAYS_28);
    send_cmd(KIND_NEXT_DAY, '0, '0, '0);
    send_cmd(KIND_NEXT_DAY, '0, '0, '0);
    send_cmd(KIND_LOAD, 14'd1900, MONTH_FEB, DAYS_28);
    send_cmd(KIND_NEXT_DAY, '0, '0, '0);
    send_cmd(KIND_LOAD, 14'd2100, 4'd3, DAY_FIRST);
    send_cmd(KIND_PREV_DAY, '0, '0, '0);
    // day loaded past month end is kept, then rolls or decrements
    send_cmd(KIND_LOAD, 14'd2024, MONTH_FEB, DAYS_31);
    send_cmd(KIND_NEXT_DAY, '0, '0, '0);
    send_cmd(KIND_LOAD, 14'd2023, MONTH_APR, DAYS_31);
    send_cmd(KIND_PREV_DAY, '0, '0, '0);
    send_cmd(KIND_SPARE_7, '0, '0, '0);
    send_cmd(KIND_LOAD, YEAR_MIN, MONTH_JAN, DAY_FIRST);
    send_cmd(KIND_PREV_MONTH, '0, '0, '0);

    // no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) send_random_cmd();
    // sender idle
    send_idle_pct  = 48;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) send_random_cmd();
    // receiver stalling
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    repeat (PHASE_ITEMS) send_random_cmd();
    // both sides
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    repeat (PHASE_ITEMS) send_random_cmd();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("requests: %0d loads, %0d day steps, %0d month steps, %0d unused kinds",
             n_loads, n_day_steps, n_month_steps, n_spare);
    $display("dates compared: %0d over four flow-control phases, mismatches: %0d",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
